>>> rtl/tsa_pkg.sv
`default_nettype none
package tsa_pkg;

  localparam int QUEUE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);
  localparam int SCAN_W      = (QUEUE_SLOTS < 8) ? QUEUE_SLOTS : 8;
  localparam int OFF_W       = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;
  localparam int SCAN_STEPS  = (QUEUE_SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int STEP_W      = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 6;
  localparam int GSLOT_W    = 6;
  localparam int FCOUNT_W   = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_FLUSH   = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_hit_t;

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] base,
                                                   input logic [OFF_W:0]    step);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + (SLOT_W + 1)'(step);
    if (sum >= (SLOT_W + 1)'(QUEUE_SLOTS)) begin
      sum = sum - (SLOT_W + 1)'(QUEUE_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/tsa_if.sv
`default_nettype none
interface tsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [tsa_pkg::ACTION_W-1:0] action;
  logic [tsa_pkg::INDEX_W-1:0]  slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

interface tsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [tsa_pkg::GSLOT_W-1:0]  granted_slot;
  logic [tsa_pkg::FCOUNT_W-1:0] free_count;
  logic                         release_error;

  modport source (output valid, output granted, output granted_slot, output free_count,
                  output release_error, input ready);
  modport sink   (input valid, input granted, input granted_slot, input free_count,
                  input release_error, output ready);
endinterface
`default_nettype wire

>>> rtl/tsa_scan.sv
`default_nettype none
module tsa_scan (
  input  wire logic [tsa_pkg::SCAN_W-1:0] used,
  output tsa_pkg::scan_hit_t               hit
);
  import tsa_pkg::*;

  // The lowest free position in the window wins.
  always_comb begin
    hit.found  = 1'b0;
    hit.offset = '0;
    for (int k = SCAN_W - 1; k >= 0; k--) begin
      if (!used[k]) begin
        hit.found  = 1'b1;
        hit.offset = OFF_W'(k);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/tx_slot_allocator.sv
`default_nettype none
// Release, flush and no-op beats go from idle to the done state, which loads the result
// register once it is free. Allocate beats first search eight slots of the used map per
// cycle through one shared window scanner, starting at the last grant.
// One beat is in flight at a time and the next is taken the cycle after the result register
// is loaded; a beat waits in the done state while an earlier result is not yet taken.
// Synchronous reset frees every slot, sets the free count to 64 and the search start to 0.
module tx_slot_allocator (
  input  wire logic clk,
  input  wire logic rst,
  tsa_req_if.sink   req,
  tsa_rsp_if.source rsp
);
  import tsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state;
  logic [QUEUE_SLOTS-1:0] slot_used;
  logic [CNT_W-1:0]    free_slots;
  logic [SLOT_W-1:0]   search_start;
  logic [SLOT_W-1:0]   cursor;
  logic [STEP_W-1:0]   step;

  logic                res_granted;
  logic [SLOT_W-1:0]   res_slot;
  logic [CNT_W-1:0]    res_count;
  logic                res_error;

  logic                out_valid;
  logic                out_granted;
  logic [GSLOT_W-1:0]  out_slot;
  logic [FCOUNT_W-1:0] out_count;
  logic                out_error;

  logic [SCAN_W-1:0]   window;
  scan_hit_t           hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                accept;
  logic                rel_bad;
  logic [SLOT_W-1:0]   rel_slot;

  always_comb begin
    for (int k = 0; k < SCAN_W; k++) begin
      window[k] = slot_used[slot_wrap(cursor, (OFF_W + 1)'(k))];
    end
  end

  tsa_scan u_scan (
    .used (window),
    .hit  (hit)
  );

  assign hit_slot = slot_wrap(cursor, {1'b0, hit.offset});
  assign accept   = req.valid && req.ready;
  assign rel_slot = req.slot_index[SLOT_W-1:0];
  assign rel_bad  = (32'(req.slot_index) >= QUEUE_SLOTS) || !slot_used[rel_slot];

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.granted       = out_granted;
  assign rsp.granted_slot  = out_slot;
  assign rsp.free_count    = out_count;
  assign rsp.release_error = out_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_used    <= '0;
      free_slots   <= CNT_W'(QUEUE_SLOTS);
      search_start <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_granted <= 1'b0;
            res_slot    <= '0;
            cursor      <= search_start;
            step        <= '0;
            case (action_t'(req.action))
              ACT_ALLOC: begin
                res_error <= 1'b0;
                res_count <= free_slots;
                state     <= ST_SCAN;
              end
              ACT_RELEASE: begin
                res_error <= rel_bad;
                state     <= ST_DONE;
                if (rel_bad) begin
                  res_count <= free_slots;
                end else begin
                  slot_used[rel_slot] <= 1'b0;
                  if (free_slots < CNT_W'(QUEUE_SLOTS)) begin
                    free_slots <= free_slots + 1'b1;
                    res_count  <= free_slots + 1'b1;
                  end else begin
                    res_count <= free_slots;
                  end
                end
              end
              ACT_FLUSH: begin
                res_error    <= 1'b0;
                slot_used    <= '0;
                free_slots   <= CNT_W'(QUEUE_SLOTS);
                search_start <= '0;
                res_count    <= CNT_W'(QUEUE_SLOTS);
                state        <= ST_DONE;
              end
              default: begin
                res_error <= 1'b0;
                res_count <= free_slots;
                state     <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit.found) begin
            slot_used[hit_slot] <= 1'b1;
            search_start        <= hit_slot;
            res_granted         <= 1'b1;
            res_slot            <= hit_slot;
            if (free_slots != '0) begin
              free_slots <= free_slots - 1'b1;
              res_count  <= free_slots - 1'b1;
            end
            state <= ST_DONE;
          end else if (step == STEP_W'(SCAN_STEPS - 1)) begin
            state <= ST_DONE;
          end else begin
            cursor <= slot_wrap(cursor, (OFF_W + 1)'(SCAN_W));
            step   <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_granted <= res_granted;
            out_slot    <= GSLOT_W'(res_slot);
            out_count   <= FCOUNT_W'(res_count);
            out_error   <= res_error;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
